/* rtl/core/csdm_pkg.sv */
// ----------------------------------------------------------------------------
// csdm_pkg
// Shared types, constants and the arctangent table for the concentric
// square-to-disk map.
// ----------------------------------------------------------------------------
package csdm_pkg;

  localparam int DATA_BITS_DEF       = 16;
  localparam int ROTATION_STAGES_DEF = 16;

  // extra fraction bits carried through the rotation
  localparam int GUARD      = 8;
  // phase is a 32-bit fraction of a full turn
  localparam int PHASE_BITS = 32;
  // ratio quotient, at most one eighth turn (2^29)
  localparam int QUO_BITS   = 30;
  // residual angle width in the rotator
  localparam int ZW         = 34;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131497;

  // quadrant codes, one per quarter turn
  localparam logic [1:0] QUAD_EAST  = 2'd0;
  localparam logic [1:0] QUAD_NORTH = 2'd1;
  localparam logic [1:0] QUAD_WEST  = 2'd2;
  localparam logic [1:0] QUAD_SOUTH = 2'd3;

  // control that travels beside the data words of each cell
  typedef struct packed {
    logic       valid;
    logic [1:0] quarter;
    logic       flip;
    logic       zero;
  } csdm_ctl_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/csdm_if.sv */
// ----------------------------------------------------------------------------
// csdm channel interfaces
// Valid/ready channels for square points in and disk points out.
// ----------------------------------------------------------------------------
interface csdm_in_if #(
  parameter int DATA_BITS = csdm_pkg::DATA_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] square_x;
  logic [DATA_BITS-1:0] square_y;

  modport source (output valid, output square_x, output square_y, input ready);
  modport sink   (input valid, input square_x, input square_y, output ready);
endinterface

interface csdm_out_if #(
  parameter int DATA_BITS = csdm_pkg::DATA_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] disk_x;
  logic signed [DATA_BITS-1:0] disk_y;

  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface

/* rtl/core/csdm_div_cell.sv */
// ----------------------------------------------------------------------------
// csdm_div_cell
// One restoring-division step: doubles the partial remainder, subtracts the
// divisor when it fits and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module csdm_div_cell #(
  parameter int DATA_BITS = csdm_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  csdm_pkg::csdm_ctl_t           ctl_i,
  input  logic [DATA_BITS:0]            den_i,
  input  logic [DATA_BITS:0]            rem_i,
  input  logic [csdm_pkg::QUO_BITS-1:0] quo_i,
  output csdm_pkg::csdm_ctl_t           ctl_o,
  output logic [DATA_BITS:0]            den_o,
  output logic [DATA_BITS:0]            rem_o,
  output logic [csdm_pkg::QUO_BITS-1:0] quo_o
);

  logic [DATA_BITS+1:0]            dbl;
  logic                            fits;
  logic [DATA_BITS:0]              rem_nxt;
  logic [csdm_pkg::QUO_BITS-1:0]   quo_nxt;
  csdm_pkg::csdm_ctl_t             ctl_r;
  logic [DATA_BITS:0]              den_r;
  logic [DATA_BITS:0]              rem_r;
  logic [csdm_pkg::QUO_BITS-1:0]   quo_r;

  // trial subtract of the doubled remainder
  always_comb begin
    dbl     = {rem_i, 1'b0};
    fits    = (dbl >= {1'b0, den_i});
    rem_nxt = fits ? (DATA_BITS+1)'(dbl - {1'b0, den_i}) : dbl[DATA_BITS:0];
    quo_nxt = {quo_i[csdm_pkg::QUO_BITS-2:0], fits};
  end

  // advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  // advance data
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.quarter <= ctl_i.quarter;
      ctl_r.flip    <= ctl_i.flip;
      ctl_r.zero    <= ctl_i.zero;
      den_r         <= den_i;
      rem_r         <= rem_nxt;
      quo_r         <= quo_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

/* rtl/core/csdm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// csdm_cordic_cell
// One CORDIC micro-rotation toward a zero residual angle.
// ----------------------------------------------------------------------------
module csdm_cordic_cell #(
  parameter int W     = 27,
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  csdm_pkg::csdm_ctl_t               ctl_i,
  input  logic signed [W-1:0]               cx_i,
  input  logic signed [W-1:0]               cy_i,
  input  logic signed [csdm_pkg::ZW-1:0]    z_i,
  output csdm_pkg::csdm_ctl_t               ctl_o,
  output logic signed [W-1:0]               cx_o,
  output logic signed [W-1:0]               cy_o,
  output logic signed [csdm_pkg::ZW-1:0]    z_o
);

  localparam logic signed [csdm_pkg::ZW-1:0] ATAN =
    signed'(csdm_pkg::ZW'(csdm_pkg::atan_turn(STAGE)));

  logic signed [W-1:0]            dx;
  logic signed [W-1:0]            dy;
  logic signed [W-1:0]            cx_nxt;
  logic signed [W-1:0]            cy_nxt;
  logic signed [csdm_pkg::ZW-1:0] z_nxt;
  csdm_pkg::csdm_ctl_t            ctl_r;
  logic signed [W-1:0]            cx_r;
  logic signed [W-1:0]            cy_r;
  logic signed [csdm_pkg::ZW-1:0] z_r;

  // rotate by plus or minus atan(2^-STAGE)
  always_comb begin
    dx = cy_i >>> STAGE;
    dy = cx_i >>> STAGE;
    if (!z_i[csdm_pkg::ZW-1]) begin
      cx_nxt = cx_i - dx;
      cy_nxt = cy_i + dy;
      z_nxt  = z_i - ATAN;
    end else begin
      cx_nxt = cx_i + dx;
      cy_nxt = cy_i - dy;
      z_nxt  = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.quarter <= ctl_i.quarter;
      ctl_r.flip    <= ctl_i.flip;
      ctl_r.zero    <= ctl_i.zero;
      cx_r          <= cx_nxt;
      cy_r          <= cy_nxt;
      z_r           <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign cx_o  = cx_r;
  assign cy_o  = cy_r;
  assign z_o   = z_r;

endmodule

/* rtl/core/concentric_square_to_disk_map.sv */
// Pipeline from input word to output word: 1 wedge select, 29 divider cells,
// 1 phase/gain multiply, the rotator cells, 1 output.
// Throughput: one word per cycle; the whole chain advances together and holds
// while the output word waits, so the rate is set by the output handshake.
// Reset: rst_n clears only the valid bits of every cell; no data is cleared.
// ----------------------------------------------------------------------------
// concentric_square_to_disk_map
// Maps a unit-square point onto the unit disk with the concentric map.
// ----------------------------------------------------------------------------
module concentric_square_to_disk_map #(
  parameter int DATA_BITS       = csdm_pkg::DATA_BITS_DEF,
  parameter int ROTATION_STAGES = csdm_pkg::ROTATION_STAGES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  csdm_in_if.sink    in_chan,
  csdm_out_if.source out_chan
);

  localparam int XW     = DATA_BITS + 2;
  localparam int W      = DATA_BITS + csdm_pkg::GUARD + 3;
  localparam int NDIV   = csdm_pkg::QUO_BITS - 1;
  localparam int ZW     = csdm_pkg::ZW;
  localparam int PW     = DATA_BITS + 1 + 32;
  localparam int GSH    = 32 - csdm_pkg::GUARD;

  logic en;

  // ---- wedge select ----
  logic signed [XW-1:0] px;
  logic signed [XW-1:0] py;
  logic signed [XW-1:0] npx;
  logic signed [XW-1:0] npy;
  logic signed [XW-1:0] major;
  logic signed [XW-1:0] minor;
  logic signed [XW-1:0] minor_abs;
  logic                 c_gt_ny;
  logic                 c_gt_y;
  logic                 c_lt_y;
  logic [1:0]           quarter;
  logic                 sub;
  logic                 major_neg;
  logic                 zero;
  logic [DATA_BITS:0]   n_w;
  logic [DATA_BITS:0]   d_w;
  logic                 q_top;

  always_comb begin
    px      = signed'({1'b0, in_chan.square_x, 1'b0}) - signed'({2'b01, {DATA_BITS{1'b0}}});
    py      = signed'({1'b0, in_chan.square_y, 1'b0}) - signed'({2'b01, {DATA_BITS{1'b0}}});
    npx     = -px;
    npy     = -py;
    c_gt_ny = (px > npy);
    c_gt_y  = (px > py);
    c_lt_y  = (px < py);
    zero    = 1'b0;
    if (c_gt_ny && c_gt_y) begin
      major = px;  minor = py; quarter = csdm_pkg::QUAD_EAST;  sub = 1'b0; major_neg = 1'b0;
    end else if (c_gt_ny) begin
      major = py;  minor = px; quarter = csdm_pkg::QUAD_NORTH; sub = 1'b1; major_neg = 1'b0;
    end else if (c_lt_y) begin
      major = npx; minor = py; quarter = csdm_pkg::QUAD_WEST;  sub = 1'b0; major_neg = 1'b1;
    end else begin
      major = npy; minor = px; quarter = csdm_pkg::QUAD_SOUTH; sub = 1'b1; major_neg = 1'b1;
      zero  = (py == '0);
    end
    minor_abs = minor[XW-1] ? -minor : minor;
    n_w       = minor_abs[DATA_BITS:0];
    d_w       = major[DATA_BITS:0];
    q_top     = (n_w >= d_w);
  end

  csdm_pkg::csdm_ctl_t           ctl_s0_r;
  logic [DATA_BITS:0]            den_s0_r;
  logic [DATA_BITS:0]            rem_s0_r;
  logic [csdm_pkg::QUO_BITS-1:0] quo_s0_r;

  // hold the wedge and the first quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s0_r.valid <= 1'b0;
    end else if (en) begin
      ctl_s0_r.valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_s0_r.quarter <= quarter;
      ctl_s0_r.flip    <= (minor[XW-1] ^ major_neg) ^ sub;
      ctl_s0_r.zero    <= zero;
      den_s0_r         <= d_w;
      rem_s0_r         <= q_top ? (n_w - d_w) : n_w;
      quo_s0_r         <= {{(csdm_pkg::QUO_BITS-1){1'b0}}, q_top};
    end
  end

  // ---- divider chain ----
  csdm_pkg::csdm_ctl_t           d_ctl [NDIV+1];
  logic [DATA_BITS:0]            d_den [NDIV+1];
  logic [DATA_BITS:0]            d_rem [NDIV+1];
  logic [csdm_pkg::QUO_BITS-1:0] d_quo [NDIV+1];

  assign d_ctl[0] = ctl_s0_r;
  assign d_den[0] = den_s0_r;
  assign d_rem[0] = rem_s0_r;
  assign d_quo[0] = quo_s0_r;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    csdm_div_cell #(.DATA_BITS(DATA_BITS)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (d_ctl[i]),
      .den_i (d_den[i]),
      .rem_i (d_rem[i]),
      .quo_i (d_quo[i]),
      .ctl_o (d_ctl[i+1]),
      .den_o (d_den[i+1]),
      .rem_o (d_rem[i+1]),
      .quo_o (d_quo[i+1])
    );
  end

  // ---- phase, quadrant split and gain ----
  logic [31:0]          ratio;
  logic [31:0]          phase;
  logic [31:0]          phase_off;
  logic [1:0]           quad;
  logic [31:0]          resid;
  logic [PW-1:0]        prod;

  always_comb begin
    ratio     = 32'(d_quo[NDIV]);
    if (d_ctl[NDIV].flip) begin
      ratio = -ratio;
    end
    phase     = d_ctl[NDIV].zero ? 32'd0 : ({d_ctl[NDIV].quarter, 30'd0} + ratio);
    phase_off = phase + 32'd536870912;
    quad      = phase_off[31:30];
    resid     = phase - {quad, 30'd0};
    prod      = PW'(d_den[NDIV]) * PW'(csdm_pkg::GAIN_Q32);
  end

  csdm_pkg::csdm_ctl_t   ctl_g_r;
  logic signed [W-1:0]   cx_g_r;
  logic signed [ZW-1:0]  z_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_g_r.valid <= 1'b0;
    end else if (en) begin
      ctl_g_r.valid <= d_ctl[NDIV].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_g_r.quarter <= quad;
      ctl_g_r.flip    <= 1'b0;
      ctl_g_r.zero    <= d_ctl[NDIV].zero;
      cx_g_r          <= signed'(W'(prod[PW-1:GSH]));
      z_g_r           <= signed'(ZW'(signed'(resid)));
    end
  end

  // ---- rotator chain ----
  csdm_pkg::csdm_ctl_t  r_ctl [ROTATION_STAGES+1];
  logic signed [W-1:0]  r_cx  [ROTATION_STAGES+1];
  logic signed [W-1:0]  r_cy  [ROTATION_STAGES+1];
  logic signed [ZW-1:0] r_z   [ROTATION_STAGES+1];

  assign r_ctl[0] = ctl_g_r;
  assign r_cx[0]  = cx_g_r;
  assign r_cy[0]  = '0;
  assign r_z[0]   = z_g_r;

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    csdm_cordic_cell #(.W(W), .STAGE(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (r_ctl[i]),
      .cx_i  (r_cx[i]),
      .cy_i  (r_cy[i]),
      .z_i   (r_z[i]),
      .ctl_o (r_ctl[i+1]),
      .cx_o  (r_cx[i+1]),
      .cy_o  (r_cy[i+1]),
      .z_o   (r_z[i+1])
    );
  end

  // ---- quadrant, rounding and saturation ----
  function automatic logic signed [DATA_BITS-1:0] to_out(input logic signed [W-1:0] v);
    logic signed [W:0] s;
    logic signed [W:0] o;
    logic signed [W:0] hi;
    logic signed [W:0] lo;
    hi = signed'((W+1)'({1'b0, {(DATA_BITS-1){1'b1}}}));
    lo = -hi - signed'((W+1)'(1));
    s  = signed'((W+1)'(v)) + signed'((W+1)'(1) << csdm_pkg::GUARD);
    o  = s >>> (csdm_pkg::GUARD + 1);
    if (o > hi) begin
      o = hi;
    end
    if (o < lo) begin
      o = lo;
    end
    return o[DATA_BITS-1:0];
  endfunction

  logic signed [W-1:0] ox;
  logic signed [W-1:0] oy;

  always_comb begin
    case (r_ctl[ROTATION_STAGES].quarter)
      csdm_pkg::QUAD_EAST: begin
        ox = r_cx[ROTATION_STAGES];  oy = r_cy[ROTATION_STAGES];
      end
      csdm_pkg::QUAD_NORTH: begin
        ox = -r_cy[ROTATION_STAGES]; oy = r_cx[ROTATION_STAGES];
      end
      csdm_pkg::QUAD_WEST: begin
        ox = -r_cx[ROTATION_STAGES]; oy = -r_cy[ROTATION_STAGES];
      end
      default: begin
        ox = r_cy[ROTATION_STAGES];  oy = -r_cx[ROTATION_STAGES];
      end
    endcase
  end

  logic                        out_valid_r;
  logic signed [DATA_BITS-1:0] disk_x_r;
  logic signed [DATA_BITS-1:0] disk_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r_ctl[ROTATION_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disk_x_r <= to_out(ox);
      disk_y_r <= to_out(oy);
    end
  end

  // advance the whole chain unless the output word is held
  assign en             = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = en;
  assign out_chan.valid = out_valid_r;
  assign out_chan.disk_x = disk_x_r;
  assign out_chan.disk_y = disk_y_r;

`ifndef NO_ASSERTIONS
  // quotient never exceeds one eighth turn away from the origin
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (d_ctl[NDIV].valid && !d_ctl[NDIV].zero) |->
      (d_quo[NDIV] <= csdm_pkg::QUO_BITS'(32'd536870912)))
    else $error("ratio quotient above an eighth turn");

  // origin flag only with a zero radius
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (d_ctl[NDIV].valid && d_ctl[NDIV].zero) |-> (d_den[NDIV] == '0))
    else $error("origin flag with nonzero radius");

  // remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (d_ctl[NDIV].valid && !d_ctl[NDIV].zero) |-> (d_rem[NDIV] < d_den[NDIV]))
    else $error("divider remainder not below divisor");

  // residual angle converges into one eighth turn
  a_z_conv: assert property (@(posedge clk) disable iff (!rst_n)
    r_ctl[ROTATION_STAGES].valid |->
      ((r_z[ROTATION_STAGES] < signed'(ZW'(32'd536870912))) &&
       (r_z[ROTATION_STAGES] > -signed'(ZW'(32'd536870912)))))
    else $error("rotator residual out of range");
`endif

endmodule

/* dv/tb_concentric_square_to_disk_map.sv */
// ----------------------------------------------------------------------------
// tb_concentric_square_to_disk_map
// Drives square points through the concentric disk map with random bursts and
// output stalls, predicts each disk point in fixed point and checks them in order.
// ----------------------------------------------------------------------------
module tb_concentric_square_to_disk_map;

  localparam int DB = 16;
  localparam int STAGES = 16;
  localparam int GB = 8;
  localparam longint EIGHTH = 64'd536870912;

  typedef struct packed {
    logic signed [DB-1:0] dx;
    logic signed [DB-1:0] dy;
  } disk_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  csdm_in_if  #(.DATA_BITS(DB)) in_chan ();
  csdm_out_if #(.DATA_BITS(DB)) out_chan ();

  concentric_square_to_disk_map #(.DATA_BITS(DB), .ROTATION_STAGES(STAGES)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always #5 clk = ~clk;

  disk_pt_t disk_queue[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int burst_left = 0;
  logic stall_mode = 1'b0;

  // floor shift of a signed value
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint ratio_turn(longint num, longint den);
    longint n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (d == 0) ? 0 : (n <<< 29) / d;
    if ((num < 0) != (den < 0)) q = -q;
    return q;
  endfunction

  function automatic logic [DB-1:0] round_sat(longint v);
    longint o;
    o = fshift(v + (64'sd1 <<< GB), GB + 1);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[DB-1:0];
  endfunction

  // disk point of one square point
  function automatic disk_pt_t map_to_disk(logic [DB-1:0] sx, logic [DB-1:0] sy);
    longint x, y, r, ph, z, cx, cy, ddx, ddy, ox, oy;
    logic [31:0] phase, rem;
    logic [1:0] quad;
    disk_pt_t p;
    x = 2 * longint'(sx) - 65536;
    y = 2 * longint'(sy) - 65536;
    if (x > -y) begin
      if (x > y) begin
        r = x; ph = ratio_turn(y, x);
      end else begin
        r = y; ph = 2 * EIGHTH - ratio_turn(x, y);
      end
    end else if (x < y) begin
      r = -x; ph = 4 * EIGHTH + ratio_turn(y, x);
    end else begin
      r = -y; ph = (y != 0) ? 6 * EIGHTH - ratio_turn(x, y) : 0;
    end
    phase = ph[31:0];
    quad = 2'((phase + 32'd536870912) >> 30);
    rem = phase - {quad, 30'd0};
    z = longint'($signed(rem));
    cx = longint'((64'(r) * 64'd2608131497) >> (32 - GB));
    cy = 0;
    for (int i = 0; i < STAGES; i++) begin
      ddx = fshift(cy, i);
      ddy = fshift(cx, i);
      if (z >= 0) begin
        cx -= ddx; cy += ddy; z -= longint'(csdm_pkg::atan_turn(i));
      end else begin
        cx += ddx; cy -= ddy; z += longint'(csdm_pkg::atan_turn(i));
      end
    end
    case (quad)
      csdm_pkg::QUAD_EAST:  begin ox = cx;  oy = cy;  end
      csdm_pkg::QUAD_NORTH: begin ox = -cy; oy = cx;  end
      csdm_pkg::QUAD_WEST:  begin ox = -cx; oy = -cy; end
      default:              begin ox = cy;  oy = -cx; end
    endcase
    p.dx = round_sat(ox);
    p.dy = round_sat(oy);
    return p;
  endfunction

  // send one word, with bursts and gaps
  task automatic send_point(logic [DB-1:0] sx, logic [DB-1:0] sy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.square_x <= sx;
    in_chan.square_y <= sy;
    disk_queue = {disk_queue, map_to_disk(sx, sy)};
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_in++;
    @(negedge clk);
  endtask

  // receiver stall pattern: alternate free-running and stalling stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_chan.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // check each result against the oldest prediction
  always @(posedge clk) begin
    disk_pt_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      words_out++;
      if (disk_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d", $time, out_chan.disk_x, out_chan.disk_y);
      end else begin
        want = disk_queue.pop_front();
        if (want.dx !== out_chan.disk_x) begin
          errors++;
          $display("%0t: disk_x expected %0d actual %0d", $time, want.dx, out_chan.disk_x);
        end
        if (want.dy !== out_chan.disk_y) begin
          errors++;
          $display("%0t: disk_y expected %0d actual %0d", $time, want.dy, out_chan.disk_y);
        end
      end
    end
  end

  // corners, center, edges, wedge diagonals and alternating bit patterns
  task automatic test_directed();
    logic [DB-1:0] edges[5] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
    foreach (edges[i]) send_point(edges[i], edges[(i + 2) % 5]);
    send_point(16'h8000, 16'h8000);
    send_point(16'hFFFF, 16'hFFFF);
    send_point(16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'h0000);
    send_point(16'h0000, 16'hFFFF);
    send_point(16'hFFFF, 16'h8000);
    send_point(16'h8000, 16'hFFFF);
    send_point(16'h0000, 16'h8000);
    send_point(16'h8000, 16'h0000);
    send_point(16'hC000, 16'h4000);
    send_point(16'h4000, 16'h4000);
    send_point(16'h8001, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'h5555, 16'hAAAA);
    send_point(16'hAAAA, 16'h5555);
  endtask

  // uniform points, plus some near the center and on the diagonals
  task automatic test_random(int count);
    logic [DB-1:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = DB'($urandom);
      b = DB'($urandom);
      case ($urandom_range(0, 5))
        0: b = a;
        1: b = ~a;
        2: begin
          a = 16'h8000 + DB'($urandom_range(0, 8)) - 16'd4;
          b = 16'h8000 + DB'($urandom_range(0, 8)) - 16'd4;
        end
        default: ;
      endcase
      send_point(a, b);
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.square_x = '0;
    in_chan.square_y = '0;
    out_chan.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1850);
    in_chan.valid <= 1'b0;
    while (disk_queue.size() != 0) @(posedge clk);
    repeat (STAGES + 40) @(posedge clk);
    $display("Sent %0d square points (edges, center, diagonals, random)", words_in);
    $display("Checked %0d disk points under bursty input and output stalls", words_out);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
